/* src/conv3_pkg.sv */
// Shared types and constants of the 3x3 fixed-point convolution block.
`timescale 1ns / 1ps

package conv3_pkg;

  localparam int FRAC_BITS = 16;
  localparam int INT_BITS  = 8;
  localparam int WORD_W    = INT_BITS + FRAC_BITS;
  localparam int PAIR_W    = 2 * WORD_W;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int RND_W     = FRAC_BITS + WORD_W;
  localparam int OUT_W     = 24;
  localparam int TAP_N     = 9;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TAPS_0_1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS_2_3 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS_4_5 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS_6_7 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_8    = 3'd4;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [TAP_N-1:0][WORD_W-1:0] taps_t;

  // One complete window on its way from the front end to the arithmetic.
  typedef struct packed {
    taps_t px;
    logic  last;
  } win_t;

  typedef struct packed {
    logic [OUT_W-1:0] conv_value;
    logic             last;
  } result_t;

endpackage

/* src/conv3x3_fixed_point_stream_top.sv */
// Top level of the streaming 3x3 fixed-point convolution block.
`timescale 1ns / 1ps

// Path of a result: window stage, window queue, product and group-sum registers, result queue.
// Throughput: one pixel per cycle, sustained while results are taken; the single
// read and single write port of the line buffer RAM and the one-deep window stage set that.
// Reset (synchronous, rst_n low) clears the frame position, all queues, pipeline valids
// and the coefficient registers. The line buffer is not cleared and needs no clearing after
// reset: every entry that feeds a result is rewritten earlier in the same frame.

module conv3x3_fixed_point_stream_top #(
  parameter int FRAME_WIDTH  = 28,
  parameter int FRAME_HEIGHT = 28
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Pixel requests.
  input  logic                                   in_push,
  output logic                                   in_full,
  input  conv3_pkg::word_t                       in_pixel,
  // Result requests.
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic [conv3_pkg::OUT_W-1:0]            out_conv_value,
  output logic                                   out_last_of_frame,
  // Coefficient register port.
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [conv3_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [conv3_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [conv3_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                   pready
);

  import conv3_pkg::*;

  // Coefficient registers. Each register is 64 bits wide on the bus, so register i
  // sits at byte address 8*i and the index is the address with its low three bits
  // dropped. Writes to indexes past the last register are ignored.
  logic [PAIR_W-1:0]    taps_01_r;
  logic [PAIR_W-1:0]    taps_23_r;
  logic [PAIR_W-1:0]    taps_45_r;
  logic [PAIR_W-1:0]    taps_67_r;
  logic [WORD_W-1:0]    tap_8_r;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                 cfg_wr;
  taps_t                taps;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_01_r <= '0;
      taps_23_r <= '0;
      taps_45_r <= '0;
      taps_67_r <= '0;
      tap_8_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TAPS_0_1: taps_01_r <= pwdata[PAIR_W-1:0];
        REG_TAPS_2_3: taps_23_r <= pwdata[PAIR_W-1:0];
        REG_TAPS_4_5: taps_45_r <= pwdata[PAIR_W-1:0];
        REG_TAPS_6_7: taps_67_r <= pwdata[PAIR_W-1:0];
        REG_TAP_8:    tap_8_r   <= pwdata[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TAPS_0_1: prdata = CFG_DATA_W'(taps_01_r);
      REG_TAPS_2_3: prdata = CFG_DATA_W'(taps_23_r);
      REG_TAPS_4_5: prdata = CFG_DATA_W'(taps_45_r);
      REG_TAPS_6_7: prdata = CFG_DATA_W'(taps_67_r);
      REG_TAP_8:    prdata = CFG_DATA_W'(tap_8_r);
      default:      prdata = '0;
    endcase
  end

  // Tap k multiplies window position k, row-major with the oldest row first.
  // Even taps live in the low half of their register, odd taps in the high half.
  assign taps[0] = taps_01_r[WORD_W-1:0];
  assign taps[1] = taps_01_r[PAIR_W-1:WORD_W];
  assign taps[2] = taps_23_r[WORD_W-1:0];
  assign taps[3] = taps_23_r[PAIR_W-1:WORD_W];
  assign taps[4] = taps_45_r[WORD_W-1:0];
  assign taps[5] = taps_45_r[PAIR_W-1:WORD_W];
  assign taps[6] = taps_67_r[WORD_W-1:0];
  assign taps[7] = taps_67_r[PAIR_W-1:WORD_W];
  assign taps[8] = tap_8_r;

  // The front end turns the pixel stream into complete windows. Windows that
  // yield a result go through a two-entry queue to the arithmetic back end, so a
  // stall at the result side does not reach the pixel side at once.
  win_t       fq_wr_data;
  win_t       fq_rd_data;
  logic       fq_push;
  logic       fq_full;
  logic       fq_pop;
  logic       fq_empty;
  logic [1:0] fq_count_unused;
  result_t    res;

  conv3_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_push),
    .pixel  (in_pixel),
    .full   (in_full),
    .q_push (fq_push),
    .q_data (fq_wr_data),
    .q_full (fq_full)
  );

  conv3_fifo #(
    .WIDTH ($bits(win_t)),
    .DEPTH (2)
  ) u_win_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fq_push),
    .wr_data (fq_wr_data),
    .full    (fq_full),
    .pop     (fq_pop),
    .rd_data (fq_rd_data),
    .empty   (fq_empty),
    .count   (fq_count_unused)
  );

  // The back end forms the nine products in one stage, rounds and adds them in
  // groups of three in the next, and writes the final sum into its result queue.
  conv3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (fq_rd_data),
    .q_empty   (fq_empty),
    .q_pop     (fq_pop),
    .taps      (taps),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (res)
  );

  assign out_conv_value    = res.conv_value;
  assign out_last_of_frame = res.last;

endmodule

/* src/conv3_ram.sv */
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps

module conv3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/conv3_fifo.sv */
// Small register-based first-in first-out queue.
`timescale 1ns / 1ps

module conv3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wr_data,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* src/conv3_front.sv */
// Front end: pixel intake, line buffer, 3x3 window and window classification.
`timescale 1ns / 1ps

module conv3_front #(
  parameter int FRAME_WIDTH  = 28,
  parameter int FRAME_HEIGHT = 28
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  conv3_pkg::word_t pixel,
  output logic             full,
  output logic             q_push,
  output conv3_pkg::win_t  q_data,
  input  logic             q_full
);

  import conv3_pkg::*;

  localparam int COL_W = $clog2(FRAME_WIDTH);
  localparam int ROW_W = $clog2(FRAME_HEIGHT);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(FRAME_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(FRAME_HEIGHT - 1);

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              s1_vld_r, s1_vld_nxt;
  logic [WORD_W-1:0] s1_px_r;
  logic [COL_W-1:0]  s1_col_r;
  logic              s1_res_r;
  logic              s1_last_r;
  taps_t             win_r, win_nxt;
  logic [PAIR_W-1:0] line_rd;
  logic              accept;
  logic              s1_adv;

  assign accept = push && !full;
  assign s1_adv = s1_vld_r && (!s1_res_r || !q_full);
  assign full   = s1_vld_r && !s1_adv;

  // Each line buffer entry holds one column: row r-1 on top, row r-2 below.
  conv3_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (FRAME_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata ({s1_px_r, line_rd[PAIR_W-1:WORD_W]}),
    .re    (accept),
    .raddr (col_r),
    .rdata (line_rd)
  );

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    s1_vld_nxt = s1_vld_r;
    if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
    if (accept) begin
      s1_vld_nxt = 1'b1;
      if (col_r == COL_LAST) begin
        col_nxt = '0;
        row_nxt = (row_r == ROW_LAST) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_nxt[k*3+0] = win_r[k*3+1];
      win_nxt[k*3+1] = win_r[k*3+2];
    end
    win_nxt[2] = line_rd[WORD_W-1:0];
    win_nxt[5] = line_rd[PAIR_W-1:WORD_W];
    win_nxt[8] = s1_px_r;
  end

  assign q_push      = s1_adv && s1_res_r;
  assign q_data.px   = win_nxt;
  assign q_data.last = s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r   <= pixel;
      s1_col_r  <= col_r;
      s1_res_r  <= (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
      s1_last_r <= (row_r == ROW_LAST) && (col_r == COL_LAST);
    end
    if (s1_adv) begin
      win_r <= win_nxt;
    end
  end

endmodule

/* src/conv3_back.sv */
// Back end: tap products, rounding, window sum and result queue.
`timescale 1ns / 1ps

module conv3_back (
  input  logic               clk,
  input  logic               rst_n,
  input  conv3_pkg::win_t    q_data,
  input  logic               q_empty,
  output logic               q_pop,
  input  conv3_pkg::taps_t   taps,
  input  logic               out_pop,
  output logic               out_empty,
  output conv3_pkg::result_t out_data
);

  import conv3_pkg::*;

  localparam int ODEPTH = 8;
  localparam int OCNT_W = $clog2(ODEPTH + 1);
  localparam logic [RND_W-1:0] RND_HALF = RND_W'(1) << (FRAC_BITS - 1);

  logic signed [PROD_W-1:0] prod_nxt [TAP_N];
  logic signed [PROD_W-1:0] prod_r   [TAP_N];
  logic                     p_vld_r;
  logic                     p_last_r;
  logic [RND_W-1:0]         rnd_full [TAP_N];
  logic [OUT_W-1:0]         rnd      [TAP_N];
  logic [OUT_W-1:0]         grp_nxt  [3];
  logic [OUT_W-1:0]         grp_r    [3];
  logic                     s_vld_r;
  logic                     s_last_r;
  result_t                  fin;
  logic [OCNT_W-1:0]        ocount;
  logic [OCNT_W-1:0]        inflight;
  logic                     ofull;

  // A window is taken only when the result queue is sure to have room for it.
  assign inflight = OCNT_W'(p_vld_r) + OCNT_W'(s_vld_r) + ocount;
  assign q_pop    = !q_empty && (inflight < OCNT_W'(ODEPTH));

  always_comb begin
    for (int k = 0; k < TAP_N; k++) begin
      prod_nxt[k] = $signed(q_data.px[k]) * $signed(taps[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < TAP_N; k++) begin
      rnd_full[k] = prod_r[k][RND_W-1:0] + RND_HALF;
      rnd[k]      = rnd_full[k][RND_W-1:FRAC_BITS];
    end
    for (int g = 0; g < 3; g++) begin
      grp_nxt[g] = rnd[g*3] + rnd[g*3+1] + rnd[g*3+2];
    end
  end

  assign fin.conv_value = grp_r[0] + grp_r[1] + grp_r[2];
  assign fin.last       = s_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
    end else begin
      p_vld_r <= q_pop;
      s_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int k = 0; k < TAP_N; k++) begin
        prod_r[k] <= prod_nxt[k];
      end
      p_last_r <= q_data.last;
    end
    if (p_vld_r) begin
      for (int g = 0; g < 3; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
      s_last_r <= p_last_r;
    end
  end

  conv3_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (ODEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (s_vld_r),
    .wr_data (fin),
    .full    (ofull),
    .pop     (out_pop),
    .rd_data (out_data),
    .empty   (out_empty),
    .count   (ocount)
  );

  // ofull never gates a write: the credit check above already reserves the slot.
  logic ofull_unused;
  assign ofull_unused = ofull;

endmodule

/* src/conv3_chk.sv */
// Port-level checker for the convolution block and its bind to the top level.
`timescale 1ns / 1ps

module conv3_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [23:0] out_conv_value,
  input logic        out_last_of_frame,
  input logic        pready
);

  // Leaving reset, no result is pending and pixels are taken at once.
  a_reset_state: assert property (@(posedge clk)
    $rose(rst_n) |-> out_empty && !in_full)
    else $error("block not idle after reset");

  // The register port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready dropped");

  // A waiting result is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty)
    else $error("waiting result withdrawn");

  // A waiting result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> $stable(out_conv_value) && $stable(out_last_of_frame))
    else $error("waiting result changed");

endmodule

bind conv3x3_fixed_point_stream_top conv3_chk u_conv3_chk (.*);
